FILE: hw/rtl/gdd_pkg.sv
// Shared types, operation codes and calendar functions for the Gregorian date decrement core.
// Used by gdd_ctrl, gdd_datapath and gregorian_date_decrement_core; no dependencies.
`default_nettype none

package gdd_pkg;

    localparam int CMD_W   = 3;
    localparam int COUNT_W = 8;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int STEP_W  = COUNT_W + 3;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_DAYS       = 3'd0,
        CMD_WEEKS      = 3'd1,
        CMD_MONTHS     = 3'd2,
        CMD_YEARS      = 3'd3,
        CMD_DECADES    = 3'd4,
        CMD_CENTURY    = 3'd5,
        CMD_MILLENNIUM = 3'd6,
        CMD_NONE       = 3'd7
    } cmd_t;

    typedef struct packed {
        logic load;
        logic fix;
        logic step;
        logic finish;
        logic send;
    } dp_cmd_t;

    typedef struct packed {
        logic steps_zero;
        logic out_free;
    } dp_status_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] a;
        logic [10:0]       r1;
        logic [8:0]        r2;
        logic              div25;
        a     = y[YEAR_W-1] ? YEAR_W'(-y) : y;
        r1    = ({3'b0, a[15:8]} << 2) + ({3'b0, a[15:8]} << 1) + {3'b0, a[7:0]};
        r2    = ({6'b0, r1[10:8]} << 2) + ({6'b0, r1[10:8]} << 1) + {1'b0, r1[7:0]};
        div25 = 1'b0;
        for (int k = 0; k < 12; k++)
        begin
            if (r2 == 9'(25 * k))
            begin
                div25 = 1'b1;
            end
        end
        return (a[1:0] == 2'b00) && (!div25 || (a[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] n;
        case (m) inside
            4'd2:                   n = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [DAY_W-1:0] clamp_day(input logic [DAY_W-1:0]   d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] n;
        n = days_in(m, y);
        return (d > n) ? n : d;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gregorian_date_decrement_core.sv
// Top level of the Gregorian date decrement core: stream ports, controller and datapath.
// Depends on gdd_pkg, gdd_ctrl and gdd_datapath.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_tvalid / s_tready           s_tdata[39:0]: cmd, count, day, month, year
// m_axis    out  m_tvalid / m_tready           m_tdata[31:0]: day, month, year
//
// One transaction at a time: after accept the controller passes FIX, RUN (one decrement per step),
// FIN and SEND, which sets m_tvalid once the output register is free, and takes the next transaction
// only back in IDLE; steps is count for days and months, 7 * count for weeks, 1 for year-type codes, 0 otherwise.
// The day/month walker retires one day or one month per cycle.
// The output register holds a result until taken; the next transaction is accepted meanwhile.
// Reset clears control state only; result payload is undefined until the first transaction.
`default_nettype none

module gregorian_date_decrement_core #(
    parameter int unsigned COUNT_MAX = 255
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [gdd_pkg::IN_W-1:0]   s_tdata,  // cmd, count, day_in, month_in, year_in
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [gdd_pkg::OUT_W-1:0]       m_tdata   // day_out, month_out, year_out
);
    import gdd_pkg::*;

    dp_cmd_t          dp_cmd;
    dp_status_t       dp_status;
    logic [DAY_W-1:0]   day_out;
    logic [MONTH_W-1:0] month_out;
    logic [YEAR_W-1:0]  year_out;

    gdd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    gdd_datapath #(
        .COUNT_MAX (COUNT_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .cmd_in    (s_tdata[2:0]),
        .count_in  (s_tdata[10:3]),
        .day_in    (s_tdata[15:11]),
        .month_in  (s_tdata[19:16]),
        .year_in   (s_tdata[35:20]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .day_out   (day_out),
        .month_out (month_out),
        .year_out  (year_out)
    );

    assign m_tdata = {7'b0, year_out, month_out, day_out};

endmodule

`default_nettype wire

FILE: hw/rtl/gdd_ctrl.sv
// Controller state machine for the Gregorian date decrement core.
// Depends on gdd_pkg; drives gdd_datapath through dp_cmd_t and reads dp_status_t.
`default_nettype none

module gdd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire gdd_pkg::dp_status_t status,
    output gdd_pkg::dp_cmd_t         cmd
);
    import gdd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIX,
        ST_RUN,
        ST_FIN,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ready_next = 1'b1;
                if (in_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIX;
                    ready_next = 1'b0;
                end
            end
            ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.steps_zero)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.send   = 1'b1;
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/gdd_datapath.sv
// Datapath for the Gregorian date decrement core: date registers, step counter, output register.
// Depends on gdd_pkg; commanded by gdd_ctrl.
`default_nettype none

module gdd_datapath #(
    parameter int unsigned COUNT_MAX = 255
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gdd_pkg::dp_cmd_t              cmd,
    output gdd_pkg::dp_status_t                status,
    input  wire logic [gdd_pkg::CMD_W-1:0]     cmd_in,
    input  wire logic [gdd_pkg::COUNT_W-1:0]   count_in,
    input  wire logic [gdd_pkg::DAY_W-1:0]     day_in,
    input  wire logic [gdd_pkg::MONTH_W-1:0]   month_in,
    input  wire logic [gdd_pkg::YEAR_W-1:0]    year_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gdd_pkg::DAY_W-1:0]          day_out,
    output logic [gdd_pkg::MONTH_W-1:0]        month_out,
    output logic [gdd_pkg::YEAR_W-1:0]         year_out
);
    import gdd_pkg::*;

    logic [DAY_W-1:0]   day_reg, day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [YEAR_W-1:0]  delta_reg, delta_next;
    cmd_t               op_reg, op_next;
    logic [DAY_W-1:0]   dout_reg;
    logic [MONTH_W-1:0] mout_reg;
    logic [YEAR_W-1:0]  yout_reg;
    logic               out_valid_reg, out_valid_next;

    logic [COUNT_W-1:0] cnt;
    logic [STEP_W-1:0]  cnt_s;
    logic [YEAR_W-1:0]  cnt_y;
    logic [MONTH_W-1:0] month_fix;

    always_comb
    begin
        cnt       = ({{(32-COUNT_W){1'b0}}, count_in} > COUNT_MAX) ? COUNT_MAX[COUNT_W-1:0]
                                                                   : count_in;
        cnt_s     = {3'b0, cnt};
        cnt_y     = {{(YEAR_W-COUNT_W){1'b0}}, cnt};
        month_fix = (month_in == 4'd0) ? 4'd1 : ((month_in > 4'd12) ? 4'd12 : month_in);
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        steps_next = steps_reg;
        delta_next = delta_reg;
        op_next    = op_reg;
        if (cmd.load)
        begin
            op_next    = cmd_t'(cmd_in);
            day_next   = (day_in == 5'd0) ? 5'd1 : day_in;
            month_next = month_fix;
            year_next  = year_in;
            unique case (cmd_t'(cmd_in))
                CMD_DAYS:       steps_next = cnt_s;
                CMD_WEEKS:      steps_next = (cnt_s << 3) - cnt_s;
                CMD_MONTHS:     steps_next = cnt_s;
                CMD_NONE:       steps_next = '0;
                default:        steps_next = STEP_W'(1);
            endcase
            unique case (cmd_t'(cmd_in))
                CMD_DECADES:    delta_next = (cnt_y << 3) + (cnt_y << 1);
                CMD_CENTURY:    delta_next = 16'd100;
                CMD_MILLENNIUM: delta_next = 16'd1000;
                default:        delta_next = cnt_y;
            endcase
        end
        else if (cmd.fix || cmd.finish)
        begin
            day_next = clamp_day(day_reg, month_reg, year_reg);
        end
        else if (cmd.step)
        begin
            steps_next = steps_reg - STEP_W'(1);
            case (op_reg) inside
                CMD_DAYS, CMD_WEEKS:
                begin
                    if (day_reg > 5'd1)
                    begin
                        day_next = day_reg - 5'd1;
                    end
                    else if (month_reg == 4'd1)
                    begin
                        day_next   = 5'd31;
                        month_next = 4'd12;
                        year_next  = year_reg - 16'd1;
                    end
                    else
                    begin
                        month_next = month_reg - 4'd1;
                        day_next   = days_in(month_reg - 4'd1, year_reg);
                    end
                end
                CMD_MONTHS:
                begin
                    day_next = clamp_day(day_reg, month_reg, year_reg);
                    if (month_reg == 4'd1)
                    begin
                        month_next = 4'd12;
                        year_next  = year_reg - 16'd1;
                    end
                    else
                    begin
                        month_next = month_reg - 4'd1;
                    end
                end
                CMD_YEARS, CMD_DECADES, CMD_CENTURY, CMD_MILLENNIUM:
                begin
                    year_next = year_reg - delta_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.send)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        delta_reg <= delta_next;
        op_reg    <= op_next;
        if (cmd.send)
        begin
            dout_reg <= day_reg;
            mout_reg <= month_reg;
            yout_reg <= year_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.steps_zero = (steps_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign day_out           = dout_reg;
    assign month_out         = mout_reg;
    assign year_out          = yout_reg;

endmodule

`default_nettype wire
